@@ rtl/core/tlnt_pkg.sv @@
// Package for the two-level name table: request and status codes, sequencer
// states and the result record.
// Used by two_level_name_table_core; depends on nothing else.
package tlnt_pkg;

  // Port widths fixed by the request and result formats
  localparam int unsigned REQ_W    = 3;
  localparam int unsigned KEY_W    = 64;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned SLOT_W   = 4;
  localparam int unsigned COUNT_W  = 5;

  typedef enum logic [REQ_W-1:0] {
    REQ_MKDIR  = 3'd0,
    REQ_MKFILE = 3'd1,
    REQ_RMFILE = 3'd2,
    REQ_FIND   = 3'd3,
    REQ_RMDIR  = 3'd4
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 3'd0,
    ST_DIR_EXISTS   = 3'd1,
    ST_DIR_MISSING  = 3'd2,
    ST_FILE_EXISTS  = 3'd3,
    ST_FILE_MISSING = 3'd4,
    ST_FULL         = 3'd5
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIR_RD,
    S_DIR_CMP,
    S_FILE_RD,
    S_FILE_CMP,
    S_FSHIFT_RD,
    S_FSHIFT_WR,
    S_DSHIFT_RD,
    S_DSHIFT_WR,
    S_ROW_RD,
    S_ROW_WR,
    S_DONE
  } state_e;

  typedef struct packed {
    status_e             status;
    logic [SLOT_W-1:0]   dir_slot;
    logic [SLOT_W-1:0]   file_slot;
    logic [COUNT_W-1:0]  dirs_in_use;
    logic [COUNT_W-1:0]  files_in_dir;
  } res_t;

endpackage

@@ rtl/core/two_level_name_table_core.sv @@
// Two-level name table: directory names, each with its own file name list.
// Top level; holds the sequencer, the name memories and the file counts.
// Depends on tlnt_pkg.
//
//   channel  | direction | handshake                | payload
//   ---------+-----------+--------------------------+----------------------------------
//   request  | in        | in_valid_i / in_stall_o  | req_type_i, dir_key_i, file_key_i
//   result   | out       | out_valid_o / out_stall_i| status_o, dir_slot_o, file_slot_o,
//            |           |                          | dirs_in_use_o, files_in_dir_o
//
// One request at a time: the sequencer scans names in slot order, reading and
// then comparing or moving each name; a removed directory's later entries and
// their file rows are moved down one place. Reset clears the state, the result
// valid flag, the directory count and all file counts only.
// A stalled result holds in the output register; the next request is taken
// meanwhile and waits at the end of its sequence for the register to free up.
module two_level_name_table_core
  import tlnt_pkg::*;
#(
  parameter int unsigned MAX_DIRS   = 16,
  parameter int unsigned MAX_FILES  = 16,
  parameter int unsigned NAME_BYTES = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [REQ_W-1:0]    req_type_i,
  input  logic [KEY_W-1:0]    dir_key_i,
  input  logic [KEY_W-1:0]    file_key_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [STATUS_W-1:0] status_o,
  output logic [SLOT_W-1:0]   dir_slot_o,
  output logic [SLOT_W-1:0]   file_slot_o,
  output logic [COUNT_W-1:0]  dirs_in_use_o,
  output logic [COUNT_W-1:0]  files_in_dir_o
);

  localparam int unsigned NAME_W = 8 * NAME_BYTES;
  localparam int unsigned DW     = (MAX_DIRS > 1) ? $clog2(MAX_DIRS) : 1;
  localparam int unsigned FW     = (MAX_FILES > 1) ? $clog2(MAX_FILES) : 1;
  localparam int unsigned DCW    = $clog2(MAX_DIRS + 1);
  localparam int unsigned FCW    = $clog2(MAX_FILES + 1);
  localparam int unsigned FADR_W = DW + FW;
  localparam int unsigned FDEPTH = MAX_DIRS * (2 ** FW);

  // Sequencer and request registers
  state_e              state_q, state_d;
  req_e                req_q, req_d;
  logic [NAME_W-1:0]   dname_q, dname_d;
  logic [NAME_W-1:0]   fname_q, fname_d;
  logic [DCW-1:0]      di_q, di_d;
  logic [FCW-1:0]      fi_q, fi_d;
  logic [DW-1:0]       dsel_q, dsel_d;
  res_t                res_q, res_d;
  logic [DCW-1:0]      dcnt_q, dcnt_d;
  logic [FCW-1:0]      fcnt_q [MAX_DIRS];
  logic                out_valid_q, out_valid_d;
  res_t                out_q, out_d;

  // Directory name memory
  logic [NAME_W-1:0]   dn_mem [MAX_DIRS];
  logic                dn_re, dn_we;
  logic [DW-1:0]       dn_raddr, dn_waddr;
  logic [NAME_W-1:0]   dn_wdata, dn_rdata_q;

  // File name memory, one row of 2**FW entries per directory
  logic [NAME_W-1:0]   fn_mem [FDEPTH];
  logic                fn_re, fn_we;
  logic [FADR_W-1:0]   fn_raddr, fn_waddr;
  logic [NAME_W-1:0]   fn_wdata, fn_rdata_q;

  // File count write port
  logic                fc_we;
  logic [DW-1:0]       fc_waddr;
  logic [FCW-1:0]      fc_wdata;

  logic [DCW-1:0]      di_inc;
  logic [FCW-1:0]      fi_inc;
  logic [DCW-1:0]      dcnt_dec;
  logic [FCW-1:0]      fcnt_sel;
  logic [FCW-1:0]      fcnt_di;
  logic [FCW-1:0]      fcnt_di_inc;

  assign di_inc      = di_q + DCW'(1);
  assign fi_inc      = fi_q + FCW'(1);
  assign dcnt_dec    = dcnt_q - DCW'(1);
  assign fcnt_sel    = fcnt_q[dsel_q];
  assign fcnt_di     = fcnt_q[di_q[DW-1:0]];
  assign fcnt_di_inc = fcnt_q[di_inc[DW-1:0]];

  assign in_stall_o     = (state_q != S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign status_o       = out_q.status;
  assign dir_slot_o     = out_q.dir_slot;
  assign file_slot_o    = out_q.file_slot;
  assign dirs_in_use_o  = out_q.dirs_in_use;
  assign files_in_dir_o = out_q.files_in_dir;

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    dname_d     = dname_q;
    fname_d     = fname_q;
    di_d        = di_q;
    fi_d        = fi_q;
    dsel_d      = dsel_q;
    res_d       = res_q;
    dcnt_d      = dcnt_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    dn_re       = 1'b0;
    dn_raddr    = di_q[DW-1:0];
    dn_we       = 1'b0;
    dn_waddr    = di_q[DW-1:0];
    dn_wdata    = dn_rdata_q;
    fn_re       = 1'b0;
    fn_raddr    = {dsel_q, fi_q[FW-1:0]};
    fn_we       = 1'b0;
    fn_waddr    = {dsel_q, fi_q[FW-1:0]};
    fn_wdata    = fn_rdata_q;
    fc_we       = 1'b0;
    fc_waddr    = dsel_q;
    fc_wdata    = fcnt_sel;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          req_d   = req_e'(req_type_i);
          dname_d = dir_key_i[NAME_W-1:0];
          fname_d = file_key_i[NAME_W-1:0];
          di_d    = '0;
          res_d   = '0;
          case (req_type_i) inside
            REQ_MKDIR, REQ_MKFILE, REQ_RMFILE, REQ_FIND, REQ_RMDIR: state_d = S_DIR_RD;
            default: state_d = S_DONE;
          endcase
        end
      end

      S_DIR_RD: begin
        if (di_q >= dcnt_q) begin
          // Directory not in the table
          if (req_q == REQ_MKDIR) begin
            if (dcnt_q == DCW'(MAX_DIRS)) begin
              res_d.status = ST_FULL;
            end else begin
              dn_we          = 1'b1;
              dn_waddr       = dcnt_q[DW-1:0];
              dn_wdata       = dname_q;
              fc_we          = 1'b1;
              fc_waddr       = dcnt_q[DW-1:0];
              fc_wdata       = '0;
              dcnt_d         = dcnt_q + DCW'(1);
              res_d.dir_slot = SLOT_W'(dcnt_q);
            end
          end else begin
            res_d.status = ST_DIR_MISSING;
          end
          state_d = S_DONE;
        end else begin
          dn_re   = 1'b1;
          state_d = S_DIR_CMP;
        end
      end

      S_DIR_CMP: begin
        if (dn_rdata_q == dname_q) begin
          dsel_d         = di_q[DW-1:0];
          res_d.dir_slot = SLOT_W'(di_q);
          fi_d           = '0;
          case (req_q)
            REQ_MKDIR: begin
              res_d.status       = ST_DIR_EXISTS;
              res_d.files_in_dir = COUNT_W'(fcnt_di);
              state_d            = S_DONE;
            end
            REQ_RMDIR: state_d = S_DSHIFT_RD;
            default:   state_d = S_FILE_RD;
          endcase
        end else begin
          di_d    = di_inc;
          state_d = S_DIR_RD;
        end
      end

      S_FILE_RD: begin
        if (fi_q >= fcnt_sel) begin
          // File not in the directory
          res_d.files_in_dir = COUNT_W'(fcnt_sel);
          if (req_q == REQ_MKFILE) begin
            if (fcnt_sel == FCW'(MAX_FILES)) begin
              res_d.status = ST_FULL;
            end else begin
              fn_we              = 1'b1;
              fn_waddr           = {dsel_q, fcnt_sel[FW-1:0]};
              fn_wdata           = fname_q;
              fc_we              = 1'b1;
              fc_wdata           = fcnt_sel + FCW'(1);
              res_d.file_slot    = SLOT_W'(fcnt_sel);
              res_d.files_in_dir = COUNT_W'(fcnt_sel + FCW'(1));
            end
          end else begin
            res_d.status = ST_FILE_MISSING;
          end
          state_d = S_DONE;
        end else begin
          fn_re   = 1'b1;
          state_d = S_FILE_CMP;
        end
      end

      S_FILE_CMP: begin
        if (fn_rdata_q == fname_q) begin
          res_d.file_slot    = SLOT_W'(fi_q);
          res_d.files_in_dir = COUNT_W'(fcnt_sel);
          case (req_q)
            REQ_MKFILE: begin
              res_d.status = ST_FILE_EXISTS;
              state_d      = S_DONE;
            end
            REQ_RMFILE: begin
              res_d.files_in_dir = COUNT_W'(fcnt_sel - FCW'(1));
              state_d            = S_FSHIFT_RD;
            end
            default: state_d = S_DONE;
          endcase
        end else begin
          fi_d    = fi_inc;
          state_d = S_FILE_RD;
        end
      end

      // Close the gap in the file list: move each later name down one place
      S_FSHIFT_RD: begin
        if (fi_inc >= fcnt_sel) begin
          fc_we    = 1'b1;
          fc_wdata = fcnt_sel - FCW'(1);
          state_d  = S_DONE;
        end else begin
          fn_re    = 1'b1;
          fn_raddr = {dsel_q, fi_inc[FW-1:0]};
          state_d  = S_FSHIFT_WR;
        end
      end

      S_FSHIFT_WR: begin
        fn_we   = 1'b1;
        fi_d    = fi_inc;
        state_d = S_FSHIFT_RD;
      end

      // Close the gap in the directory list, moving each row of files along
      S_DSHIFT_RD: begin
        if (di_inc >= dcnt_q) begin
          dcnt_d   = dcnt_dec;
          fc_we    = 1'b1;
          fc_waddr = dcnt_dec[DW-1:0];
          fc_wdata = '0;
          state_d  = S_DONE;
        end else begin
          dn_re    = 1'b1;
          dn_raddr = di_inc[DW-1:0];
          state_d  = S_DSHIFT_WR;
        end
      end

      S_DSHIFT_WR: begin
        dn_we    = 1'b1;
        fc_we    = 1'b1;
        fc_waddr = di_q[DW-1:0];
        fc_wdata = fcnt_di_inc;
        fi_d     = '0;
        state_d  = S_ROW_RD;
      end

      S_ROW_RD: begin
        if (fi_q >= fcnt_di) begin
          di_d    = di_inc;
          state_d = S_DSHIFT_RD;
        end else begin
          fn_re    = 1'b1;
          fn_raddr = {di_inc[DW-1:0], fi_q[FW-1:0]};
          state_d  = S_ROW_WR;
        end
      end

      S_ROW_WR: begin
        fn_we    = 1'b1;
        fn_waddr = {di_q[DW-1:0], fi_q[FW-1:0]};
        fi_d     = fi_inc;
        state_d  = S_ROW_RD;
      end

      S_DONE: begin
        // Hold until the output register is free
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d       = 1'b1;
          out_d             = res_q;
          out_d.dirs_in_use = COUNT_W'(dcnt_q);
          state_d           = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      dcnt_q      <= '0;
      out_valid_q <= 1'b0;
      fcnt_q      <= '{default: '0};
    end else begin
      state_q     <= state_d;
      dcnt_q      <= dcnt_d;
      out_valid_q <= out_valid_d;
      if (fc_we) begin
        fcnt_q[fc_waddr] <= fc_wdata;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q   <= req_d;
    dname_q <= dname_d;
    fname_q <= fname_d;
    di_q    <= di_d;
    fi_q    <= fi_d;
    dsel_q  <= dsel_d;
    res_q   <= res_d;
    out_q   <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (dn_we) begin
      dn_mem[dn_waddr] <= dn_wdata;
    end
    if (dn_re) begin
      dn_rdata_q <= dn_mem[dn_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (fn_we) begin
      fn_mem[fn_waddr] <= fn_wdata;
    end
    if (fn_re) begin
      fn_rdata_q <= fn_mem[fn_raddr];
    end
  end

endmodule
